// ===== rtl/lslf_pkg.sv =====
// Shared types, widths and constants for the least-squares line fit block.
// Used by lslf_serial_alu and least_squares_line_fit; depends on nothing.
`default_nettype none

package lslf_pkg;

  // Default configuration
  localparam int LSLF_MAX_POINTS = 1024;
  localparam int LSLF_FRAC_BITS  = 16;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int OUT_W   = 48;
  localparam int PTS_W   = 11;

  // Point multiplier: one 4-bit digit of the multiplier per cycle
  localparam int PROD_W     = 2 * COORD_W;
  localparam int DIG_W      = 4;
  localparam int PT_DIGITS  = COORD_W / DIG_W;
  localparam int DIG_CNT_W  = $clog2(PT_DIGITS);

  // Output saturation limits, as magnitudes
  localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  // Width helpers, all evaluated at elaboration
  function automatic int lslf_cnt_w(input int max_points);
    return $clog2(max_points + 1);
  endfunction

  // sum of x or y
  function automatic int lslf_sum1_w(input int max_points);
    return COORD_W + lslf_cnt_w(max_points);
  endfunction

  // sum of x*y or x*x
  function automatic int lslf_sum2_w(input int max_points);
    return PROD_W + lslf_cnt_w(max_points);
  endfunction

  // n*Sxx and the denominator; also covers Sx*Sy
  function automatic int lslf_den_w(input int max_points);
    return lslf_cnt_w(max_points) + lslf_sum2_w(max_points);
  endfunction

  // signed numerator
  function automatic int lslf_num_w(input int max_points);
    return lslf_den_w(max_points) + 1;
  endfunction

  // slope magnitude, before clamping
  function automatic int lslf_slope_w(input int max_points, input int frac_bits);
    return lslf_num_w(max_points) + frac_bits;
  endfunction

  // slope times Sx
  function automatic int lslf_prod_w(input int max_points, input int frac_bits);
    return lslf_slope_w(max_points, frac_bits) + lslf_sum1_w(max_points);
  endfunction

  // serial unit data width (dividend / product)
  function automatic int lslf_dv_w(input int max_points, input int frac_bits);
    return lslf_prod_w(max_points, frac_bits) + 1;
  endfunction

  // Serial arithmetic unit interface
  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } lslf_alu_op_e;

  typedef struct packed {
    logic         start;
    lslf_alu_op_e op;
  } lslf_alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lslf_alu_sts_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PT_MUL,
    S_PT_ADD,
    S_FIT_P1,
    S_FIT_P2,
    S_FIT_P3,
    S_FIT_P4,
    S_FIT_DIV,
    S_FIT_P5,
    S_FIT_INT,
    S_FINISH
  } lslf_state_e;

  // Channel payloads
  typedef struct packed {
    logic signed [COORD_W-1:0] x_value;
    logic signed [COORD_W-1:0] y_value;
    logic                      last_point;
  } lslf_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] slope_fixed;
    logic signed [OUT_W-1:0] intercept_fixed;
    logic                    degenerate;
    logic                    saturated;
    logic [PTS_W-1:0]        points_used;
  } lslf_out_t;

endpackage

`default_nettype wire

// ===== rtl/lslf_serial_alu.sv =====
// Bit-serial unsigned multiply (shift-add, one multiplier bit per cycle) and
// restoring divide (one quotient bit per cycle). Depends on lslf_pkg.
`default_nettype none

module lslf_serial_alu import lslf_pkg::*; #(
  parameter int MAX_POINTS = LSLF_MAX_POINTS,
  parameter int FRAC_BITS  = LSLF_FRAC_BITS
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire lslf_alu_req_t                                 req_i,
  input  wire logic [lslf_dv_w(MAX_POINTS, FRAC_BITS)-1:0]   opa_i,
  input  wire logic [lslf_den_w(MAX_POINTS)-1:0]             opb_i,
  output lslf_alu_sts_t                                      sts_o,
  output logic [lslf_dv_w(MAX_POINTS, FRAC_BITS)-1:0]        result_o
);

  localparam int DV_W   = lslf_dv_w(MAX_POINTS, FRAC_BITS);
  localparam int DEN_W  = lslf_den_w(MAX_POINTS);
  localparam int SX_W   = lslf_sum1_w(MAX_POINTS);
  localparam int STEP_W = $clog2(DV_W);

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(SX_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DV_W - 1);

  logic                busy_q;
  logic                done_q;
  lslf_alu_op_e        op_q;
  logic [STEP_W-1:0]   step_q;
  logic [DV_W-1:0]     acc_q;
  logic [DV_W-1:0]     shf_q;   // multiplicand, or dividend/quotient
  logic [DEN_W-1:0]    opb_q;   // multiplier, or divisor
  logic [DEN_W-1:0]    rem_q;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_sub;
  logic                rem_ge;

  // Restoring divide step
  assign rem_sh  = {rem_q, shf_q[DV_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, opb_q};
  assign rem_sub = rem_sh - {1'b0, opb_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (step_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q   <= req_i.op;
      step_q <= (req_i.op == ALU_MUL) ? MUL_LAST : DIV_LAST;
      acc_q  <= '0;
      shf_q  <= opa_i;
      opb_q  <= opb_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      unique case (op_q)
        ALU_MUL: begin
          if (opb_q[0]) begin
            acc_q <= acc_q + shf_q;
          end
          shf_q <= shf_q << 1;
          opb_q <= opb_q >> 1;
        end
        ALU_DIV: begin
          rem_q <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          shf_q <= {shf_q[DV_W-2:0], rem_ge};
        end
      endcase
    end
  end

  assign result_o   = (op_q == ALU_MUL) ? acc_q : shf_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/least_squares_line_fit.sv =====
// Least-squares straight-line fit over a stream of points: top level with
// point accumulation, fit sequencer and output register. Depends on lslf_pkg
// and lslf_serial_alu.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one point
//   (x, y, last_point) per transaction. Output channel (out_valid_o /
//   out_stall_i / out_data_o) carries one fit per set, issued on the point
//   marked last. Both channels move a transaction when valid is high and
//   stall is low.
//   Points are taken one at a time: each is accepted, runs four 4-bit digit
//   steps of the x*y / x*x multiplier and updates the sums; no new point is
//   taken until then, nor during a fit. After the last point the fit runs
//   five multiplies and two divides of the full dividend width through one
//   bit-serial unit; a degenerate set skips the slope divide.
//   Points beyond MAX_POINTS are not accumulated; a last one still fits.
//   Reset clears the count and all sums and empties the output register.
//   A finished fit waits in the output register while the receiver stalls;
//   points of the next set are taken meanwhile, and a second fit holds in
//   its final step until the register is free.
`default_nettype none

module least_squares_line_fit import lslf_pkg::*; #(
  parameter int MAX_POINTS = LSLF_MAX_POINTS,
  parameter int FRAC_BITS  = LSLF_FRAC_BITS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire lslf_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output lslf_out_t      out_data_o
);

  localparam int CW    = lslf_cnt_w(MAX_POINTS);
  localparam int SX_W  = lslf_sum1_w(MAX_POINTS);
  localparam int SP_W  = lslf_sum2_w(MAX_POINTS);
  localparam int DEN_W = lslf_den_w(MAX_POINTS);
  localparam int NUM_W = lslf_num_w(MAX_POINTS);
  localparam int SL_W  = lslf_slope_w(MAX_POINTS, FRAC_BITS);
  localparam int PR_W  = lslf_prod_w(MAX_POINTS, FRAC_BITS);
  localparam int DV_W  = lslf_dv_w(MAX_POINTS, FRAC_BITS);
  localparam int T_W   = PR_W + 2;

  localparam logic [CW-1:0]        CNT_MAX  = CW'(MAX_POINTS);
  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(PT_DIGITS - 1);

  // Sequencer
  lslf_state_e state_q, state_d;
  logic        issued_q, issued_d;
  logic        load_out;

  // Serial unit
  lslf_alu_req_t    alu_req;
  lslf_alu_sts_t    alu_sts;
  logic [DV_W-1:0]  alu_opa;
  logic [DEN_W-1:0] alu_opb;
  logic [DV_W-1:0]  alu_res;
  logic             fit_done;

  // Point stage
  logic signed [COORD_W-1:0] x_q, y_q;
  logic                      last_q;
  logic                      acc_en_q;
  logic                      xy_neg_q;
  logic [PROD_W-1:0]         cand_q;
  logic [COORD_W-1:0]        xdig_q, ydig_q;
  logic [PROD_W-1:0]         pxy_q, pxx_q;
  logic [DIG_CNT_W-1:0]      pdig_q;
  logic [PROD_W-1:0]         pp_xy, pp_xx;
  logic [COORD_W-1:0]        x_mag_in, y_mag_in;
  logic                      in_acc;

  // Running sums
  logic [CW-1:0]           cnt_q;
  logic signed [SX_W-1:0]  sum_x_q, sum_y_q;
  logic signed [SP_W-1:0]  sum_xy_q, sum_xx_q;
  logic signed [SP_W-1:0]  pxy_ext, pxx_ext;

  // Fit values
  logic signed [NUM_W-1:0] num_q;
  logic [DEN_W-1:0]        den_q;
  logic [SL_W-1:0]         slope_mag_q;
  logic                    slope_neg_q;
  logic                    degen_q;
  logic signed [T_W-1:0]   t_q;
  logic [DV_W-1:0]         icpt_mag_q;
  logic                    icpt_neg_q;

  logic                    sx_neg, sy_neg, sxy_neg;
  logic [SX_W-1:0]         sx_mag, sy_mag;
  logic [SP_W-1:0]         sxy_mag;
  logic [NUM_W-1:0]        num_mag;
  logic [T_W-1:0]          t_mag;
  logic signed [NUM_W-1:0] p_num;
  logic signed [T_W-1:0]   sy_sh, p5_term;
  logic [OUT_W:0]          slope_cl, icpt_cl;

  // Output register
  logic      out_valid_q;
  lslf_out_t out_data_q;

  // Saturate a sign/magnitude value to the output range; MSB is the flag
  function automatic logic [OUT_W:0] clamp_out(input logic [DV_W-1:0] mag, input logic neg);
    logic [DV_W-1:0]  lim;
    logic             over;
    logic [OUT_W-1:0] val;
    lim  = neg ? DV_W'(OUT_NEG_MAG) : DV_W'(OUT_POS_MAX);
    over = mag > lim;
    if (over) begin
      val = neg ? OUT_NEG_MAG : OUT_POS_MAX;
    end else begin
      val = neg ? (~mag[OUT_W-1:0] + 1'b1) : mag[OUT_W-1:0];
    end
    return {over, val};
  endfunction

  assign in_acc   = in_valid_i && !in_stall_o;
  assign fit_done = issued_q && alu_sts.done;

  // Input magnitudes
  assign x_mag_in = in_data_i.x_value[COORD_W-1] ? COORD_W'(-in_data_i.x_value)
                                                 : in_data_i.x_value;
  assign y_mag_in = in_data_i.y_value[COORD_W-1] ? COORD_W'(-in_data_i.y_value)
                                                 : in_data_i.y_value;

  // Digit partial products
  assign pp_xy = PROD_W'(cand_q * ydig_q[DIG_W-1:0]);
  assign pp_xx = PROD_W'(cand_q * xdig_q[DIG_W-1:0]);

  assign pxy_ext = $signed({{(SP_W-PROD_W){1'b0}}, pxy_q});
  assign pxx_ext = $signed({{(SP_W-PROD_W){1'b0}}, pxx_q});

  // Sign and magnitude of the sums for the fit
  assign sx_neg  = sum_x_q[SX_W-1];
  assign sy_neg  = sum_y_q[SX_W-1];
  assign sxy_neg = sum_xy_q[SP_W-1];
  assign sx_mag  = sx_neg ? SX_W'(-sum_x_q) : SX_W'(sum_x_q);
  assign sy_mag  = sy_neg ? SX_W'(-sum_y_q) : SX_W'(sum_y_q);
  assign sxy_mag = sxy_neg ? SP_W'(-sum_xy_q) : SP_W'(sum_xy_q);
  assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign t_mag   = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);

  assign p_num   = $signed({1'b0, alu_res[DEN_W-1:0]});
  assign sy_sh   = T_W'(sum_y_q) <<< FRAC_BITS;
  assign p5_term = $signed({2'b00, alu_res[PR_W-1:0]});

  assign slope_cl = clamp_out(DV_W'(slope_mag_q), slope_neg_q);
  assign icpt_cl  = clamp_out(icpt_mag_q, icpt_neg_q);

  assign in_stall_o = (state_q != S_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Next state, unit requests and operands
  always_comb begin
    state_d       = state_q;
    issued_d      = issued_q;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    load_out      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PT_MUL;
        end
      end
      S_PT_MUL: begin
        if (pdig_q == DIG_LAST) begin
          state_d = S_PT_ADD;
        end
      end
      S_PT_ADD: begin
        state_d = last_q ? S_FIT_P1 : S_IDLE;
      end
      S_FIT_P1: begin
        alu_opa = DV_W'(sxy_mag);
        alu_opb = DEN_W'(cnt_q);
        if (!issued_q) begin
          alu_req.start = 1'b1;
          issued_d      = 1'b1;
        end else if (alu_sts.done) begin
          issued_d = 1'b0;
          state_d  = S_FIT_P2;
        end
      end
      S_FIT_P2: begin
        alu_opa = DV_W'(sx_mag);
        alu_opb = DEN_W'(sy_mag);
        if (!issued_q) begin
          alu_req.start = 1'b1;
          issued_d      = 1'b1;
        end else if (alu_sts.done) begin
          issued_d = 1'b0;
          state_d  = S_FIT_P3;
        end
      end
      S_FIT_P3: begin
        alu_opa = DV_W'($unsigned(sum_xx_q));
        alu_opb = DEN_W'(cnt_q);
        if (!issued_q) begin
          alu_req.start = 1'b1;
          issued_d      = 1'b1;
        end else if (alu_sts.done) begin
          issued_d = 1'b0;
          state_d  = S_FIT_P4;
        end
      end
      S_FIT_P4: begin
        alu_opa = DV_W'(sx_mag);
        alu_opb = DEN_W'(sx_mag);
        if (!issued_q) begin
          alu_req.start = 1'b1;
          issued_d      = 1'b1;
        end else if (alu_sts.done) begin
          issued_d = 1'b0;
          state_d  = S_FIT_DIV;
        end
      end
      S_FIT_DIV: begin
        alu_req.op = ALU_DIV;
        alu_opa    = DV_W'(num_mag) << FRAC_BITS;
        alu_opb    = den_q;
        if (den_q == '0) begin
          // all x equal: slope forced to zero, no divide
          state_d = S_FIT_P5;
        end else if (!issued_q) begin
          alu_req.start = 1'b1;
          issued_d      = 1'b1;
        end else if (alu_sts.done) begin
          issued_d = 1'b0;
          state_d  = S_FIT_P5;
        end
      end
      S_FIT_P5: begin
        alu_opa = DV_W'(slope_mag_q);
        alu_opb = DEN_W'(sx_mag);
        if (!issued_q) begin
          alu_req.start = 1'b1;
          issued_d      = 1'b1;
        end else if (alu_sts.done) begin
          issued_d = 1'b0;
          state_d  = S_FIT_INT;
        end
      end
      S_FIT_INT: begin
        alu_req.op = ALU_DIV;
        alu_opa    = t_mag[DV_W-1:0];
        alu_opb    = DEN_W'(cnt_q);
        if (!issued_q) begin
          alu_req.start = 1'b1;
          issued_d      = 1'b1;
        end else if (alu_sts.done) begin
          issued_d = 1'b0;
          state_d  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Point capture and digit-serial products
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q      <= in_data_i.x_value;
      y_q      <= in_data_i.y_value;
      last_q   <= in_data_i.last_point;
      acc_en_q <= cnt_q < CNT_MAX;
      xy_neg_q <= in_data_i.x_value[COORD_W-1] ^ in_data_i.y_value[COORD_W-1];
      cand_q   <= PROD_W'(x_mag_in);
      xdig_q   <= x_mag_in;
      ydig_q   <= y_mag_in;
      pxy_q    <= '0;
      pxx_q    <= '0;
      pdig_q   <= '0;
    end else if (state_q == S_PT_MUL) begin
      pxy_q  <= pxy_q + pp_xy;
      pxx_q  <= pxx_q + pp_xx;
      cand_q <= cand_q << DIG_W;
      xdig_q <= xdig_q >> DIG_W;
      ydig_q <= ydig_q >> DIG_W;
      pdig_q <= pdig_q + 1'b1;
    end
  end

  // Running sums, cleared after each fit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
    end else if (load_out) begin
      cnt_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
    end else if ((state_q == S_PT_ADD) && acc_en_q) begin
      cnt_q    <= cnt_q + 1'b1;
      sum_x_q  <= sum_x_q + SX_W'(x_q);
      sum_y_q  <= sum_y_q + SX_W'(y_q);
      sum_xy_q <= xy_neg_q ? (sum_xy_q - pxy_ext) : (sum_xy_q + pxy_ext);
      sum_xx_q <= sum_xx_q + pxx_ext;
    end
  end

  // Fit values captured from the serial unit
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_FIT_P1: begin
        if (fit_done) begin
          num_q <= sxy_neg ? -p_num : p_num;
        end
      end
      S_FIT_P2: begin
        if (fit_done) begin
          num_q <= (sx_neg ^ sy_neg) ? (num_q + p_num) : (num_q - p_num);
        end
      end
      S_FIT_P3: begin
        if (fit_done) begin
          den_q <= alu_res[DEN_W-1:0];
        end
      end
      S_FIT_P4: begin
        if (fit_done) begin
          den_q <= den_q - alu_res[DEN_W-1:0];
        end
      end
      S_FIT_DIV: begin
        if (den_q == '0) begin
          slope_mag_q <= '0;
          slope_neg_q <= 1'b0;
          degen_q     <= 1'b1;
        end else if (fit_done) begin
          slope_mag_q <= alu_res[SL_W-1:0];
          slope_neg_q <= num_q[NUM_W-1];
          degen_q     <= 1'b0;
        end
      end
      S_FIT_P5: begin
        if (fit_done) begin
          t_q <= (slope_neg_q ^ sx_neg) ? (sy_sh + p5_term) : (sy_sh - p5_term);
        end
      end
      S_FIT_INT: begin
        if (fit_done) begin
          icpt_mag_q <= alu_res;
          icpt_neg_q <= t_q[T_W-1];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.slope_fixed     <= slope_cl[OUT_W-1:0];
      out_data_q.intercept_fixed <= icpt_cl[OUT_W-1:0];
      out_data_q.degenerate      <= degen_q;
      out_data_q.saturated       <= slope_cl[OUT_W] | icpt_cl[OUT_W];
      out_data_q.points_used     <= PTS_W'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Shared multiply/divide unit
  lslf_serial_alu #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .opa_i    (alu_opa),
    .opb_i    (alu_opb),
    .sts_o    (alu_sts),
    .result_o (alu_res)
  );

  // Checks
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_sts.busy)
    else $error("serial unit started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_sts.done |-> $past(alu_sts.busy))
    else $error("serial unit done without a run");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("point count above limit");

  a_degen_zero_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |-> (out_data_o.slope_fixed == '0))
    else $error("degenerate fit with nonzero slope");

endmodule

`default_nettype wire

// ===== dv/least_squares_line_fit_tb.sv =====
// Self-checking testbench for least_squares_line_fit: drives point sets with random
// idling and back-pressure and checks every fit against an exact integer predictor.
// Depends on lslf_pkg and the least_squares_line_fit RTL.
`default_nettype none

module least_squares_line_fit_tb;
  import lslf_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Kind of data carried by one random set
  typedef enum int {
    SET_WIDE,
    SET_NARROW,
    SET_FLAT_X,
    SET_CORNERS
  } set_shape_e;

  localparam wide_t OUT_HI = (wide_t'(1) <<< (OUT_W - 1)) - wide_t'(1);
  localparam wide_t OUT_LO = -(wide_t'(1) <<< (OUT_W - 1));
  localparam int TAIL_CYCLES = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  lslf_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  lslf_out_t out_data_o;

  least_squares_line_fit #(
    .MAX_POINTS(LSLF_MAX_POINTS),
    .FRAC_BITS (LSLF_FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Running sums mirrored from the block, and fits still to come out
  int        fit_count;
  longint    fit_sum_x;
  longint    fit_sum_y;
  longint    fit_sum_xy;
  longint    fit_sum_xx;
  lslf_out_t pending_fits[$];

  int err_count;
  int points_sent;
  int fits_checked;
  int degenerate_fits;
  int saturated_fits;
  int tx_quiet_left;

  // Receiver stall control
  int rx_hold_len;
  int rx_hold_cnt;
  int rx_run;
  bit rx_stall_val;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("timeout with %0d fits outstanding", pending_fits.size());
    $display("least_squares_line_fit_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t fit %0d: %s got %0d want %0d", $time, fits_checked, what, got, want);
    err_count++;
  endtask

  function automatic logic signed [OUT_W-1:0] clamp_out(input wide_t v, inout bit sat);
    if (v > OUT_HI) begin
      sat = 1'b1;
      return OUT_HI[OUT_W-1:0];
    end
    if (v < OUT_LO) begin
      sat = 1'b1;
      return OUT_LO[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

  // Accumulate one accepted point; on the last point work out the fit
  task automatic track_point(input lslf_in_t pt);
    longint    x, y, n, num, den;
    wide_t     slope_w, icpt_w;
    lslf_out_t fit;
    bit        sat;
    x = longint'($signed(pt.x_value));
    y = longint'($signed(pt.y_value));
    if (fit_count < LSLF_MAX_POINTS) begin
      fit_count++;
      fit_sum_x  += x;
      fit_sum_y  += y;
      fit_sum_xy += x * y;
      fit_sum_xx += x * x;
    end
    if (pt.last_point) begin
      n   = fit_count;
      num = n * fit_sum_xy - fit_sum_x * fit_sum_y;
      den = n * fit_sum_xx - fit_sum_x * fit_sum_x;
      sat = 1'b0;
      fit.degenerate = (den == 0);
      // signed division truncates toward zero
      if (den == 0) slope_w = '0;
      else slope_w = (wide_t'(num) <<< LSLF_FRAC_BITS) / wide_t'(den);
      icpt_w = ((wide_t'(fit_sum_y) <<< LSLF_FRAC_BITS) - slope_w * wide_t'(fit_sum_x))
               / wide_t'(n);
      fit.slope_fixed     = clamp_out(slope_w, sat);
      fit.intercept_fixed = clamp_out(icpt_w, sat);
      fit.saturated       = sat;
      fit.points_used     = n[PTS_W-1:0];
      pending_fits.push_back(fit);
      if (fit.degenerate) degenerate_fits++;
      if (sat) saturated_fits++;
      fit_count  = 0;
      fit_sum_x  = 0;
      fit_sum_y  = 0;
      fit_sum_xy = 0;
      fit_sum_xx = 0;
    end
  endtask

  // Sender idle length: mostly none or short, a few long, with quiet stretches
  function automatic int next_tx_gap();
    int r;
    if (tx_quiet_left > 0) begin
      tx_quiet_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      tx_quiet_left = $urandom_range(100, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Offer one point and hold it until the block takes it
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input bit last);
    lslf_in_t pt;
    int       gap;
    pt.x_value    = x;
    pt.y_value    = y;
    pt.last_point = last;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(posedge clk_i); while (in_stall_o);
    track_point(pt);
    points_sent++;
    gap = next_tx_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input set_shape_e shape);
    int v;
    case (shape)
      SET_NARROW: begin
        v = $urandom_range(16) - 8;
      end
      SET_CORNERS: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v[COORD_W-1:0];
  endfunction

  // Stop offering, then wait until every expected fit has come out
  task automatic wait_fits_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern, plus a long hold-off on request
  always @(negedge clk_i) begin : rx_stall_gen
    int r;
    if (rx_hold_len != 0) begin
      rx_hold_cnt = rx_hold_len;
      rx_hold_len = 0;
    end
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        r = $urandom_range(99);
        if (r < 8) begin
          rx_stall_val = 1'b0;
          rx_run = $urandom_range(200, 50);
        end else if (r < 55) begin
          rx_stall_val = 1'b0;
          rx_run = $urandom_range(20, 1);
        end else if (r < 92) begin
          rx_stall_val = 1'b1;
          rx_run = $urandom_range(3, 1);
        end else begin
          rx_stall_val = 1'b1;
          rx_run = $urandom_range(40, 10);
        end
      end
      rx_run--;
      out_stall_i <= rx_stall_val;
    end
  end

  // Compare each fit transaction with the oldest expected one
  always @(posedge clk_i) begin : fit_check
    lslf_out_t want;
    lslf_out_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (pending_fits.size() == 0) begin
        report_mismatch("fit with none pending, points_used", longint'(got.points_used), 0);
      end else begin
        want = pending_fits.pop_front();
        if (got.slope_fixed !== want.slope_fixed)
          report_mismatch("slope_fixed", longint'(got.slope_fixed),
                          longint'(want.slope_fixed));
        if (got.intercept_fixed !== want.intercept_fixed)
          report_mismatch("intercept_fixed", longint'(got.intercept_fixed),
                          longint'(want.intercept_fixed));
        if (got.degenerate !== want.degenerate)
          report_mismatch("degenerate", longint'(got.degenerate), longint'(want.degenerate));
        if (got.saturated !== want.saturated)
          report_mismatch("saturated", longint'(got.saturated), longint'(want.saturated));
        if (got.points_used !== want.points_used)
          report_mismatch("points_used", longint'(got.points_used),
                          longint'(want.points_used));
        fits_checked++;
      end
    end
  end

  // Corner coordinates, steep slopes and a line that does not divide evenly
  task automatic test_extremes();
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b1);
    send_point(16'sd32766, 16'sd32767, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b1);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(-16'sd32767, -16'sd32768, 1'b1);
    send_point(16'sd1, 16'sd3, 1'b0);
    send_point(16'sd2, 16'sd1, 1'b0);
    send_point(16'sd3, -16'sd1, 1'b0);
    send_point(16'sd4, -16'sd4, 1'b1);
  endtask

  // Single point, all-zero point and sets with every x equal
  task automatic test_degenerate_sets();
    send_point(-16'sd32768, 16'sd32767, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd5, 16'sd100, 1'b0);
    send_point(16'sd5, -16'sd200, 1'b0);
    send_point(16'sd5, 16'sd7, 1'b1);
  endtask

  // Set longer than MAX_POINTS: extra points are dropped, then sums must be clear
  task automatic test_long_set();
    int len;
    len = LSLF_MAX_POINTS + 6;
    for (int i = 0; i < len; i++)
      send_point(pick_coord(SET_WIDE), pick_coord(SET_WIDE), i == len - 1);
    send_point(16'sd10, -16'sd3, 1'b0);
    send_point(-16'sd7, 16'sd9, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b1);
  endtask

  // Receiver holds off long while several sets arrive back to back
  task automatic test_backpressure();
    wait_fits_drained();
    rx_hold_len = 2000;
    tx_quiet_left = 30;
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < 5; i++)
        send_point(pick_coord(SET_NARROW), pick_coord(SET_WIDE), i == 4);
    wait_fits_drained();
  endtask

  // Well-formed random sets of mostly small size
  task automatic test_random_sets(input int target);
    int                         start_pts;
    int                         len;
    int                         r;
    set_shape_e                 shape;
    logic signed [COORD_W-1:0]  flat_x;
    start_pts = points_sent;
    while (points_sent - start_pts < target) begin
      r = $urandom_range(99);
      if (r < 75) len = $urandom_range(8, 1);
      else if (r < 97) len = $urandom_range(40, 9);
      else len = $urandom_range(160, 41);
      shape  = set_shape_e'($urandom_range(3));
      flat_x = pick_coord(SET_WIDE);
      for (int i = 0; i < len; i++) begin
        if (shape == SET_FLAT_X) send_point(flat_x, pick_coord(SET_WIDE), i == len - 1);
        else send_point(pick_coord(shape), pick_coord(shape), i == len - 1);
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    rx_hold_len   = 0;
    rx_hold_cnt   = 0;
    rx_run        = 0;
    rx_stall_val  = 1'b0;
    tx_quiet_left = 0;
    err_count     = 0;
    points_sent   = 0;
    fits_checked  = 0;
    fit_count     = 0;
    fit_sum_x     = 0;
    fit_sum_y     = 0;
    fit_sum_xy    = 0;
    fit_sum_xx    = 0;
    degenerate_fits = 0;
    saturated_fits  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_degenerate_sets();
    test_long_set();
    test_backpressure();
    test_random_sets(880);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_fits_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d points in %0d fits (%0d degenerate, %0d clamped), incl. an",
             points_sent, fits_checked, degenerate_fits, saturated_fits);
    $display("over-long set and a long output hold-off; %0d mismatches", err_count);
    if (err_count == 0 && pending_fits.size() == 0) begin
      $display("least_squares_line_fit_tb: done, clean");
    end else begin
      $display("least_squares_line_fit_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
